/* rtl/core/lkv_pkg.sv */
package lkv_pkg;

  typedef enum logic {
    OP_GET = 1'b0,
    OP_PUT = 1'b1
  } lkv_op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_RESP
  } lkv_state_e;

  typedef struct packed {
    lkv_op_e            operation;
    logic signed [31:0] key;
    logic signed [31:0] value;
  } lkv_in_t;

  typedef struct packed {
    logic               found;
    logic signed [31:0] read_value;
  } lkv_out_t;

  // recency update command to the rank file
  typedef struct packed {
    logic touch;
    logic all_older;
    logic insert;
    logic grow;
  } lkv_rank_op_t;

  localparam int unsigned CfgWidth = 5;
  localparam int unsigned EntryWidth = 64;

endpackage

/* rtl/core/lkv_mem.sv */
module lkv_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 64
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/lkv_rank.sv */
module lkv_rank #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  lkv_pkg::lkv_rank_op_t                         op_i,
  input  logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] slot_i,
  input  logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] thr_i,
  input  logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] rd_idx_i,
  output logic                                          rd_valid_o,
  output logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] rd_rank_o,
  output logic [$clog2(CAPACITY + 1)-1:0]               used_o
);
  import lkv_pkg::*;

  localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned UW = $clog2(CAPACITY + 1);

  logic [CAPACITY-1:0] valid_q, valid_d;
  logic [IW-1:0]       rank_q [CAPACITY];
  logic [IW-1:0]       rank_d [CAPACITY];
  logic [UW-1:0]       used_q, used_d;

  always_comb begin
    valid_d = valid_q;
    rank_d  = rank_q;
    used_d  = used_q;
    if (op_i.touch) begin
      for (int i = 0; i < int'(CAPACITY); i++) begin
        if (IW'(i) == slot_i) begin
          rank_d[i] = '0;
          if (op_i.insert) begin
            valid_d[i] = 1'b1;
          end
        end else if (valid_q[i] && (op_i.all_older || rank_q[i] < thr_i)) begin
          rank_d[i] = rank_q[i] + IW'(1);
        end
      end
      if (op_i.grow) begin
        used_d = used_q + UW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      used_q  <= '0;
    end else begin
      valid_q <= valid_d;
      used_q  <= used_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rank_q <= rank_d;
  end

  assign rd_valid_o = valid_q[rd_idx_i];
  assign rd_rank_o  = rank_q[rd_idx_i];
  assign used_o     = used_q;

  a_used_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    UW'($countones(valid_q)) == used_q)
    else $error("entry count out of step with valid bits");

  a_used_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= UW'(CAPACITY))
    else $error("entry count above capacity");

endmodule

/* rtl/core/lkv_ctrl.sv */
module lkv_ctrl #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          in_valid_i,
  output logic                                          in_stall_o,
  input  lkv_pkg::lkv_in_t                              in_data_i,
  input  logic [lkv_pkg::CfgWidth-1:0]                  cap_i,
  output logic                                          res_valid_o,
  input  logic                                          res_ready_i,
  output lkv_pkg::lkv_out_t                             res_o,
  output logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] mem_raddr_o,
  input  logic [lkv_pkg::EntryWidth-1:0]                mem_rdata_i,
  output logic                                          mem_we_o,
  output logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] mem_waddr_o,
  output logic [lkv_pkg::EntryWidth-1:0]                mem_wdata_o,
  output lkv_pkg::lkv_rank_op_t                         rank_op_o,
  output logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] rank_slot_o,
  output logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] rank_thr_o,
  output logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] rank_idx_o,
  input  logic                                          rank_valid_i,
  input  logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] rank_i,
  input  logic [$clog2(CAPACITY + 1)-1:0]               used_i
);
  import lkv_pkg::*;

  localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned UW = $clog2(CAPACITY + 1);
  localparam int unsigned EW = (UW > CfgWidth) ? UW : CfgWidth;
  localparam logic [IW-1:0] LastIdx = IW'(CAPACITY - 1);

  lkv_state_e state_q, state_d;

  lkv_op_e            op_q, op_d;
  logic signed [31:0] key_q, key_d;
  logic signed [31:0] value_q, value_d;

  logic          iss_done_q, iss_done_d;
  logic [IW-1:0] iss_q, iss_d;
  logic          cmp_vld_q, cmp_vld_d;
  logic [IW-1:0] cmp_idx_q, cmp_idx_d;

  logic          hit_q, hit_d;
  logic [IW-1:0] hit_slot_q, hit_slot_d;
  logic [IW-1:0] hit_rank_q, hit_rank_d;
  logic [31:0]   hit_data_q, hit_data_d;
  logic          free_have_q, free_have_d;
  logic [IW-1:0] free_slot_q, free_slot_d;
  logic          lru_have_q, lru_have_d;
  logic [IW-1:0] lru_slot_q, lru_slot_d;
  logic [IW-1:0] lru_rank_q, lru_rank_d;

  lkv_out_t res_q, res_d;

  logic [CfgWidth-1:0] cap_eff;
  logic                full;
  logic [31:0]         rd_key;
  logic                key_match;

  assign cap_eff   = (cap_i == '0) ? CfgWidth'(1) : cap_i;
  assign full      = (EW'(used_i) >= EW'(CAPACITY)) || (EW'(used_i) >= EW'(cap_eff));
  assign rd_key    = mem_rdata_i[63:32];
  assign key_match = rank_valid_i && (rd_key == key_q);

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    key_d       = key_q;
    value_d     = value_q;
    iss_d       = iss_q;
    iss_done_d  = iss_done_q;
    cmp_vld_d   = 1'b0;
    cmp_idx_d   = cmp_idx_q;
    hit_d       = hit_q;
    hit_slot_d  = hit_slot_q;
    hit_rank_d  = hit_rank_q;
    hit_data_d  = hit_data_q;
    free_have_d = free_have_q;
    free_slot_d = free_slot_q;
    lru_have_d  = lru_have_q;
    lru_slot_d  = lru_slot_q;
    lru_rank_d  = lru_rank_q;
    res_d       = res_q;

    in_stall_o  = 1'b1;
    res_valid_o = 1'b0;
    mem_we_o    = 1'b0;
    mem_waddr_o = hit_slot_q;
    mem_wdata_o = {key_q, value_q};
    rank_op_o   = '0;
    rank_slot_o = hit_slot_q;
    rank_thr_o  = hit_rank_q;

    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          op_d        = in_data_i.operation;
          key_d       = in_data_i.key;
          value_d     = in_data_i.value;
          iss_d       = '0;
          iss_done_d  = 1'b0;
          hit_d       = 1'b0;
          free_have_d = 1'b0;
          lru_have_d  = 1'b0;
          state_d     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // issue stage: one entry read per cycle
        if (!iss_done_q) begin
          cmp_vld_d = 1'b1;
          cmp_idx_d = iss_q;
          if (iss_q == LastIdx) begin
            iss_done_d = 1'b1;
          end else begin
            iss_d = iss_q + IW'(1);
          end
        end
        // compare stage on the entry read last cycle
        if (cmp_vld_q) begin
          if (key_match) begin
            hit_d      = 1'b1;
            hit_slot_d = cmp_idx_q;
            hit_rank_d = rank_i;
            hit_data_d = mem_rdata_i[31:0];
          end
          if (!rank_valid_i && !free_have_q) begin
            free_have_d = 1'b1;
            free_slot_d = cmp_idx_q;
          end
          if (rank_valid_i && (!lru_have_q || rank_i > lru_rank_q)) begin
            lru_have_d = 1'b1;
            lru_slot_d = cmp_idx_q;
            lru_rank_d = rank_i;
          end
          if (cmp_idx_q == LastIdx) begin
            state_d = ST_UPDATE;
          end
        end
      end
      ST_UPDATE: begin
        res_d.found      = hit_q;
        res_d.read_value = (hit_q && op_q == OP_GET) ? hit_data_q : '0;
        if (hit_q) begin
          rank_op_o.touch = 1'b1;
          mem_we_o        = (op_q == OP_PUT);
        end else if (op_q == OP_PUT) begin
          mem_we_o         = 1'b1;
          rank_op_o.touch  = 1'b1;
          rank_op_o.insert = 1'b1;
          if (full) begin
            // reuse the least recent slot
            mem_waddr_o = lru_slot_q;
            rank_slot_o = lru_slot_q;
            rank_thr_o  = lru_rank_q;
          end else begin
            mem_waddr_o         = free_slot_q;
            rank_slot_o         = free_slot_q;
            rank_op_o.all_older = 1'b1;
            rank_op_o.grow      = 1'b1;
          end
        end
        state_d = ST_RESP;
      end
      ST_RESP: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign mem_raddr_o = iss_q;
  assign rank_idx_o  = cmp_idx_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      iss_done_q  <= 1'b0;
      cmp_vld_q   <= 1'b0;
      hit_q       <= 1'b0;
      free_have_q <= 1'b0;
      lru_have_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      iss_done_q  <= iss_done_d;
      cmp_vld_q   <= cmp_vld_d;
      hit_q       <= hit_d;
      free_have_q <= free_have_d;
      lru_have_q  <= lru_have_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    key_q       <= key_d;
    value_q     <= value_d;
    iss_q       <= iss_d;
    cmp_idx_q   <= cmp_idx_d;
    hit_slot_q  <= hit_slot_d;
    hit_rank_q  <= hit_rank_d;
    hit_data_q  <= hit_data_d;
    free_slot_q <= free_slot_d;
    lru_slot_q  <= lru_slot_d;
    lru_rank_q  <= lru_rank_d;
    res_q       <= res_d;
  end

  a_free_slot_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPDATE && !hit_q && op_q == OP_PUT && !full) |-> free_have_q)
    else $error("insert without a free slot");

  a_victim_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPDATE && !hit_q && op_q == OP_PUT && full) |-> lru_have_q)
    else $error("eviction without a victim");

endmodule

/* rtl/core/lru_key_value_cache.sv */
// Fully associative key-value cache with least-recently-used replacement.
// Each input transfer is a get or a put; each gives exactly one result:
// found tells whether the key was present before the operation, and
// read_value carries the stored value on a get hit (zero otherwise).
// Keys and values sit in a single-port-read memory that one comparator
// scans an entry per cycle, so an item occupies the block through accept,
// a scan of every entry, update and result hand-off, and longer while the
// output register is full and stalled. Input stall is low only while idle
// and stays high from acceptance until the result has been handed off. The
// result waits in an output register, so the next item can start while it
// is still stalled.
// cfg_wdata_i sets how many entries may be held before evicting; 0 acts as 1
// and values above CAPACITY act as CAPACITY. Write it only while idle.
module lru_key_value_cache #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [lkv_pkg::CfgWidth-1:0] cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  lkv_pkg::lkv_in_t             in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output lkv_pkg::lkv_out_t            out_data_o
);
  import lkv_pkg::*;

  localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned UW = $clog2(CAPACITY + 1);

  logic [CfgWidth-1:0] capacity_q;
  logic                out_valid_q, out_valid_d;
  lkv_out_t            out_data_q, out_data_d;

  logic            res_valid;
  logic            res_ready;
  lkv_out_t        res;
  logic [IW-1:0]   mem_raddr;
  logic [EntryWidth-1:0] mem_rdata;
  logic            mem_we;
  logic [IW-1:0]   mem_waddr;
  logic [EntryWidth-1:0] mem_wdata;
  lkv_rank_op_t    rank_op;
  logic [IW-1:0]   rank_slot;
  logic [IW-1:0]   rank_thr;
  logic [IW-1:0]   rank_idx;
  logic            rank_valid;
  logic [IW-1:0]   rank;
  logic [UW-1:0]   used;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CfgWidth'(16);
    end else if (cfg_we_i) begin
      capacity_q <= cfg_wdata_i;
    end
  end

  lkv_ctrl #(
    .CAPACITY(CAPACITY)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .cap_i       (capacity_q),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .rank_op_o   (rank_op),
    .rank_slot_o (rank_slot),
    .rank_thr_o  (rank_thr),
    .rank_idx_o  (rank_idx),
    .rank_valid_i(rank_valid),
    .rank_i      (rank),
    .used_i      (used)
  );

  lkv_mem #(
    .DEPTH(CAPACITY),
    .WIDTH(EntryWidth)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  lkv_rank #(
    .CAPACITY(CAPACITY)
  ) u_rank (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .op_i      (rank_op),
    .slot_i    (rank_slot),
    .thr_i     (rank_thr),
    .rd_idx_i  (rank_idx),
    .rd_valid_o(rank_valid),
    .rd_rank_o (rank),
    .used_o    (used)
  );

  // output register
  assign res_ready = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
      out_data_d  = res;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
